// ===== hw/rtl/slps_pkg.sv =====
// Shared types and constants for the status LED pattern sequencer.
// No dependencies; used by slps_led_chan and status_led_pattern_sequencer.
`timescale 1ns / 1ps
`default_nettype none

package slps_pkg;

	// Field widths
	localparam int CMD_W     = 2;
	localparam int LED_IDX_W = 2;
	localparam int PAT_W     = 3;
	localparam int PULSES_W  = 8;
	localparam int LEVELS_W  = 4;
	localparam int SUB_W     = 5;
	localparam int FAST_W    = 3;
	localparam int SLOW_W    = 5;

	// Stream widths; the tdata widths are padded to whole bytes
	localparam int IN_TDATA_W  = 16;
	localparam int IN_TUSER_W  = CMD_W;
	localparam int OUT_TDATA_W = 8;

	// Config port
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 4;

	localparam int NUM_LEDS_DEFAULT = 4;

	// Timing constants in ticks
	localparam int FAST_HALF = 4;
	localparam int SLOW_HALF = 10;
	localparam int CODE_ON   = 3;
	localparam int CODE_OFF  = 3;
	localparam int CODE_GAP  = 16;

	// Command codes
	localparam logic [CMD_W-1:0] CMD_TICK     = 2'd0;
	localparam logic [CMD_W-1:0] CMD_SET_PAT  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_SET_CODE = 2'd2;

	// Pattern codes; 5..7 behave as off
	localparam logic [PAT_W-1:0] PAT_OFF   = 3'd0;
	localparam logic [PAT_W-1:0] PAT_SOLID = 3'd1;
	localparam logic [PAT_W-1:0] PAT_BLINK = 3'd2;
	localparam logic [PAT_W-1:0] PAT_SLOW  = 3'd3;
	localparam logic [PAT_W-1:0] PAT_CODE  = 3'd4;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MASTER_EN   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DRIVEN_MASK = 1'd1;

	// Per-LED control for one accepted item
	typedef struct packed {
		logic                tick;
		logic                set_pattern;
		logic                set_code;
		logic [PAT_W-1:0]    pattern;
		logic [PULSES_W-1:0] pulses;
	} led_ctrl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/slps_led_chan.sv =====
// One LED channel: pattern, pulse-code count and code phase.
// Depends on slps_pkg.
`timescale 1ns / 1ps
`default_nettype none

module slps_led_chan (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire slps_pkg::led_ctrl_t ctrl,
	input  wire logic               fast_on,
	input  wire logic               slow_on,
	output logic                    on
);

	logic [slps_pkg::PAT_W-1:0]    pattern_q;
	logic [slps_pkg::PULSES_W-1:0] count_q;
	logic [slps_pkg::PULSES_W-1:0] pidx_q;
	logic [slps_pkg::SUB_W-1:0]    sub_q;

	logic [slps_pkg::PULSES_W-1:0] pidx_d;
	logic [slps_pkg::SUB_W-1:0]    sub_d;
	logic [slps_pkg::SUB_W-1:0]    sub_inc;

	assign sub_inc = sub_q + 1'b1;

	// Level before gating and next code phase for a tick
	always_comb begin
		on     = 1'b0;
		pidx_d = pidx_q;
		sub_d  = sub_q;
		unique case (pattern_q)
			slps_pkg::PAT_SOLID: begin
				on = 1'b1;
			end
			slps_pkg::PAT_BLINK: begin
				on = fast_on;
			end
			slps_pkg::PAT_SLOW: begin
				on = slow_on;
			end
			slps_pkg::PAT_CODE: begin
				if (count_q == '0) begin
					pidx_d = '0;
					sub_d  = '0;
				end else if (pidx_q < count_q) begin
					on = (sub_q < slps_pkg::SUB_W'(slps_pkg::CODE_ON));
					if (sub_inc >= slps_pkg::SUB_W'(slps_pkg::CODE_ON + slps_pkg::CODE_OFF)) begin
						sub_d  = '0;
						pidx_d = pidx_q + 1'b1;
					end else begin
						sub_d = sub_inc;
					end
				end else begin
					if (sub_inc >= slps_pkg::SUB_W'(slps_pkg::CODE_GAP)) begin
						sub_d  = '0;
						pidx_d = '0;
					end else begin
						sub_d = sub_inc;
					end
				end
			end
			default: begin
				pidx_d = '0;
				sub_d  = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_q <= slps_pkg::PAT_OFF;
			count_q   <= '0;
			pidx_q    <= '0;
			sub_q     <= '0;
		end else begin
			if (ctrl.set_pattern) begin
				pattern_q <= ctrl.pattern;
			end
			if (ctrl.set_code) begin
				pattern_q <= slps_pkg::PAT_CODE;
				count_q   <= ctrl.pulses;
			end
			if (ctrl.tick) begin
				pidx_q <= pidx_d;
				sub_q  <= sub_d;
			end
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/status_led_pattern_sequencer.sv =====
// Top level of the status LED pattern sequencer: stream ports, config
// registers, shared blink phases and the result register. Depends on
// slps_pkg and slps_led_chan.
`timescale 1ns / 1ps
`default_nettype none

// The block takes one command per transfer on the s_ side and returns LED
// levels on the m_ side. A tick command advances every driven LED by one tick
// and produces one transfer carrying the levels; set-pattern and set-code
// commands update one LED and produce nothing; command 3 is dropped. Every
// command is handled in the cycle it is accepted: per-LED state and the shared
// fast/slow blink phases update at that edge and the levels land in a single
// output register, valid the cycle after the tick transfer, so one command per
// clock is sustained. s_tready is low only
// while a result sits in the output register and m_tready is low; in that case
// the register frees up and a new command enters in the same cycle the result
// is taken. Fast blink is 4 ticks on / 4 off, slow blink 10 on / 10 off, a
// pulse code is N pulses of 3 on / 3 off followed by a 16-tick dark gap.
// The master enable (register 0) forces all levels low without stopping the
// sequencing; driven_mask (register 1) freezes and darkens LEDs whose bit is 0.
// Configuration writes are taken every cycle and apply to the next command.
module status_led_pattern_sequencer #(
	parameter int NUM_LEDS = slps_pkg::NUM_LEDS_DEFAULT
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// s_tuser: cmd[1:0]
	// s_tdata: led[1:0], pattern[4:2], pulses[12:5], zero[15:13]
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	input  wire logic [slps_pkg::IN_TDATA_W-1:0] s_tdata,
	input  wire logic [slps_pkg::IN_TUSER_W-1:0] s_tuser,
	// m_tdata: levels[3:0], zero[7:4]
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	output logic [slps_pkg::OUT_TDATA_W-1:0]     m_tdata,
	// config write channel
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [slps_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [slps_pkg::CFG_DATA_W-1:0] cfg_data
);

	// Only LEDs with a bit in driven_mask and levels can ever be driven
	localparam int ACTIVE_LEDS = (NUM_LEDS < slps_pkg::LEVELS_W) ? NUM_LEDS
	                                                             : slps_pkg::LEVELS_W;

	// Unpack the command
	logic [slps_pkg::CMD_W-1:0]     in_cmd;
	logic [slps_pkg::LED_IDX_W-1:0] in_led;
	logic [slps_pkg::PAT_W-1:0]     in_pattern;
	logic [slps_pkg::PULSES_W-1:0]  in_pulses;

	assign in_cmd     = s_tuser;
	assign in_led     = s_tdata[1:0];
	assign in_pattern = s_tdata[4:2];
	assign in_pulses  = s_tdata[12:5];

	// Config registers
	logic                          master_en_q;
	logic [slps_pkg::LEVELS_W-1:0] driven_mask_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			master_en_q   <= 1'b1;
			driven_mask_q <= '1;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				slps_pkg::REG_MASTER_EN:   master_en_q   <= cfg_data[0];
				slps_pkg::REG_DRIVEN_MASK: driven_mask_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Handshake: take a command whenever the output register is empty or draining
	logic m_tvalid_q;
	logic accept;
	logic do_tick;
	logic do_set_pat;
	logic do_set_code;

	assign s_tready    = !m_tvalid_q || m_tready;
	assign accept      = s_tvalid && s_tready;
	assign do_tick     = accept && (in_cmd == slps_pkg::CMD_TICK);
	assign do_set_pat  = accept && (in_cmd == slps_pkg::CMD_SET_PAT);
	assign do_set_code = accept && (in_cmd == slps_pkg::CMD_SET_CODE);

	// Shared blink phases advance on every tick, regardless of mask and enable
	logic [slps_pkg::FAST_W-1:0] fast_phase_q;
	logic [slps_pkg::SLOW_W-1:0] slow_phase_q;
	logic                        fast_on;
	logic                        slow_on;

	assign fast_on = (fast_phase_q < slps_pkg::FAST_W'(slps_pkg::FAST_HALF));
	assign slow_on = (slow_phase_q < slps_pkg::SLOW_W'(slps_pkg::SLOW_HALF));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fast_phase_q <= '0;
			slow_phase_q <= '0;
		end else if (do_tick) begin
			// fast phase wraps at 8 by width
			fast_phase_q <= fast_phase_q + 1'b1;
			if (slow_phase_q == slps_pkg::SLOW_W'(2 * slps_pkg::SLOW_HALF - 1)) begin
				slow_phase_q <= '0;
			end else begin
				slow_phase_q <= slow_phase_q + 1'b1;
			end
		end
	end

	// Per-LED channels
	logic [ACTIVE_LEDS-1:0] led_on;

	for (genvar i = 0; i < ACTIVE_LEDS; i++) begin : g_led
		slps_pkg::led_ctrl_t ctrl;
		logic                sel;

		assign sel              = (in_led == slps_pkg::LED_IDX_W'(i));
		assign ctrl.tick        = do_tick && driven_mask_q[i];
		assign ctrl.set_pattern = do_set_pat && sel;
		assign ctrl.set_code    = do_set_code && sel;
		assign ctrl.pattern     = in_pattern;
		assign ctrl.pulses      = in_pulses;

		slps_led_chan u_chan (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctrl    (ctrl),
			.fast_on (fast_on),
			.slow_on (slow_on),
			.on      (led_on[i])
		);
	end

	// Gate with mask and master enable; LEDs past the active range read 0
	logic [slps_pkg::LEVELS_W-1:0] levels_d;
	logic [slps_pkg::LEVELS_W-1:0] levels_q;

	assign levels_d = master_en_q
		? slps_pkg::LEVELS_W'(led_on & driven_mask_q[ACTIVE_LEDS-1:0])
		: '0;

	// Result register: hold until taken, reload on a tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (do_tick) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (do_tick) begin
			levels_q <= levels_d;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = slps_pkg::OUT_TDATA_W'(levels_q);

endmodule

`default_nettype wire
